/* rtl/core/bdsd_pkg.sv */
// ---------------------------------------------------------------------------
// bdsd_pkg: shared definitions for the bounded deque with sort and dedup
// Widths, command and status codes, sequencer states and compare flags.
// ---------------------------------------------------------------------------
`default_nettype none

package bdsd_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int FUNC_W    = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 7;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SORT       = 3'd5;
  localparam logic [FUNC_W-1:0] FN_DEDUP      = 3'd6;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUMP_RD,
    ST_DUMP_EMIT,
    ST_SORT_LD,
    ST_SORT_LDW,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_TAIL,
    ST_DD_RDK,
    ST_DD_LDK,
    ST_DD_RDJ,
    ST_DD_CMP,
    ST_DD_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

/* rtl/core/bdsd_if.sv */
// ---------------------------------------------------------------------------
// bdsd_if: request channels of the bounded deque
// Command channel and result channel, each with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface bdsd_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [bdsd_pkg::FUNC_W-1:0]      func;
  logic signed [bdsd_pkg::VALUE_W-1:0]     value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface bdsd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic        [bdsd_pkg::STATUS_W-1:0]    status;
  logic signed [bdsd_pkg::VALUE_W-1:0]     data;
  logic        [bdsd_pkg::ENTRIES_W-1:0]   entries;
  logic                                    last;

  modport source (output valid, output status, output data, output entries,
                  output last, input ready);
  modport sink   (input valid, input status, input data, input entries,
                  input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/bdsd_ram.sv */
// ---------------------------------------------------------------------------
// bdsd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bdsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bdsd_alu.sv */
// ---------------------------------------------------------------------------
// bdsd_alu: shared ring address and compare unit
// Maps a position from the front to a slot address, and compares two values.
// ---------------------------------------------------------------------------
`default_nettype none

module bdsd_alu #(
  parameter int DEPTH = bdsd_pkg::DEPTH_DEF
) (
  input  wire logic        [$clog2(DEPTH)-1:0]       head,
  input  wire logic        [$clog2(DEPTH)-1:0]       idx,
  input  wire logic signed [bdsd_pkg::VALUE_W-1:0]   a,
  input  wire logic signed [bdsd_pkg::VALUE_W-1:0]   b,
  output logic             [$clog2(DEPTH)-1:0]       addr,
  output bdsd_pkg::cmp_t                             cmp
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  logic [AW:0] sum;
  logic [AW:0] wrapped;

  always_comb begin
    sum     = {1'b0, head} + {1'b0, idx};
    wrapped = (sum >= DEPTH_W) ? (sum - DEPTH_W) : sum;
    addr    = wrapped[AW-1:0];
    cmp.gt  = (a > b);
    cmp.eq  = (a == b);
  end

endmodule

`default_nettype wire

/* rtl/core/bounded_deque_sort_dedup.sv */
// ---------------------------------------------------------------------------
// bounded_deque_sort_dedup: bounded deque of signed words with sort and dedup
// Ring of DEPTH slots in one RAM, walked by a small sequencer that shares one
// ring address adder and one comparator.
// ---------------------------------------------------------------------------
//   channel    dir   handshake           payload
//   in_chan    in    valid/ready         func, value
//   out_chan   out   valid/ready         status, data, entries, last
//
// Push, pop and the unused code finish in ST_IDLE. Dump reads and emits each
// entry in turn, stalling while the result register is busy. Sort runs bubble
// passes, at most n, until a pass makes no swap, then reports; dedup checks
// each entry against those kept so far, up to n(n-1)/2 compares. Every step
// goes through the single RAM port pair and the shared adder/comparator.
// Reset clears state, head, count and output valid; slot contents stay undefined.
// in_chan.ready is low while a command is in progress or the result register
// is full and not being drained.
`default_nettype none

module bounded_deque_sort_dedup #(
  parameter int DEPTH = bdsd_pkg::DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  bdsd_in_if.sink            in_chan,
  bdsd_out_if.source         out_chan
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(DEPTH - 1);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  bdsd_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic signed [bdsd_pkg::VALUE_W-1:0] hold_r, hold_nxt;
  logic swapped_r, swapped_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  logic [bdsd_pkg::STATUS_W-1:0]        out_status_r;
  logic signed [bdsd_pkg::VALUE_W-1:0]  out_data_r;
  logic [bdsd_pkg::ENTRIES_W-1:0]       out_entries_r;
  logic                                 out_last_r;

  logic                                 emit;
  logic [bdsd_pkg::STATUS_W-1:0]        emit_status;
  logic signed [bdsd_pkg::VALUE_W-1:0]  emit_data;
  logic                                 emit_last;

  logic                                 out_free;
  logic                                 in_accept;

  logic [CW-1:0]                        idx_sel;
  logic [AW-1:0]                        ring_addr;
  bdsd_pkg::cmp_t                       cmp;

  logic                                 wr_en;
  logic                                 rd_en;
  logic signed [bdsd_pkg::VALUE_W-1:0]  wr_data;
  logic [bdsd_pkg::VALUE_W-1:0]         rd_data;
  logic signed [bdsd_pkg::VALUE_W-1:0]  rd_val;

  assign rd_val    = $signed(rd_data);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == bdsd_pkg::ST_IDLE) && out_free;
  assign in_accept = in_chan.valid && in_chan.ready;

  bdsd_alu #(.DEPTH(DEPTH)) u_alu (
    .head (head_r),
    .idx  (idx_sel[AW-1:0]),
    .a    (hold_r),
    .b    (rd_val),
    .addr (ring_addr),
    .cmp  (cmp)
  );

  bdsd_ram #(.WIDTH(bdsd_pkg::VALUE_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ring_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ring_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdsd_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    j_r       <= j_nxt;
    kept_r    <= kept_nxt;
    hold_r    <= hold_nxt;
    swapped_r <= swapped_nxt;
    if (emit) begin
      out_status_r  <= emit_status;
      out_data_r    <= emit_data;
      out_entries_r <= bdsd_pkg::ENTRIES_W'(count_nxt);
      out_last_r    <= emit_last;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    kept_nxt    = kept_r;
    hold_nxt    = hold_r;
    swapped_nxt = swapped_r;
    emit        = 1'b0;
    emit_status = bdsd_pkg::STAT_OK;
    emit_data   = '0;
    emit_last   = 1'b1;
    idx_sel     = '0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_data     = in_chan.value;

    unique case (state_r)
      bdsd_pkg::ST_IDLE: begin
        priority if (in_chan.func == bdsd_pkg::FN_PUSH_FRONT) begin
          idx_sel = LAST_C;
        end else if (in_chan.func == bdsd_pkg::FN_PUSH_BACK) begin
          idx_sel = count_r;
        end else if (in_chan.func == bdsd_pkg::FN_POP_FRONT) begin
          idx_sel = ONE_C;
        end else begin
          idx_sel = '0;
        end
        if (in_accept) begin
          unique case (in_chan.func)
            bdsd_pkg::FN_PUSH_FRONT, bdsd_pkg::FN_PUSH_BACK: begin
              emit = 1'b1;
              if (count_r == DEPTH_C) begin
                emit_status = bdsd_pkg::STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + ONE_C;
                if (in_chan.func == bdsd_pkg::FN_PUSH_FRONT) begin
                  head_nxt = ring_addr;
                end
              end
            end
            bdsd_pkg::FN_POP_FRONT, bdsd_pkg::FN_POP_BACK: begin
              emit = 1'b1;
              if (count_r == '0) begin
                emit_status = bdsd_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_r - ONE_C;
                if (in_chan.func == bdsd_pkg::FN_POP_FRONT) begin
                  head_nxt = ring_addr;
                end
              end
            end
            bdsd_pkg::FN_DUMP: begin
              if (count_r == '0) begin
                emit        = 1'b1;
                emit_status = bdsd_pkg::STAT_EMPTY;
              end else begin
                k_nxt     = '0;
                state_nxt = bdsd_pkg::ST_DUMP_RD;
              end
            end
            bdsd_pkg::FN_SORT: begin
              if (count_r < TWO_C) begin
                emit = 1'b1;
              end else begin
                state_nxt = bdsd_pkg::ST_SORT_LD;
              end
            end
            bdsd_pkg::FN_DEDUP: begin
              if (count_r == '0) begin
                emit = 1'b1;
              end else begin
                k_nxt     = '0;
                kept_nxt  = '0;
                state_nxt = bdsd_pkg::ST_DD_RDK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      bdsd_pkg::ST_DUMP_RD: begin
        idx_sel   = k_r;
        rd_en     = 1'b1;
        state_nxt = bdsd_pkg::ST_DUMP_EMIT;
      end

      bdsd_pkg::ST_DUMP_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = rd_val;
          k_nxt     = k_r + ONE_C;
          emit_last = (k_nxt == count_r);
          state_nxt = emit_last ? bdsd_pkg::ST_IDLE : bdsd_pkg::ST_DUMP_RD;
        end
      end

      bdsd_pkg::ST_SORT_LD: begin
        idx_sel   = '0;
        rd_en     = 1'b1;
        state_nxt = bdsd_pkg::ST_SORT_LDW;
      end

      bdsd_pkg::ST_SORT_LDW: begin
        hold_nxt    = rd_val;
        k_nxt       = ONE_C;
        swapped_nxt = 1'b0;
        state_nxt   = bdsd_pkg::ST_SORT_RD;
      end

      bdsd_pkg::ST_SORT_RD: begin
        idx_sel   = k_r;
        rd_en     = 1'b1;
        state_nxt = bdsd_pkg::ST_SORT_CMP;
      end

      bdsd_pkg::ST_SORT_CMP: begin
        idx_sel = k_r - ONE_C;
        wr_en   = 1'b1;
        if (cmp.gt) begin
          wr_data     = rd_val;
          swapped_nxt = 1'b1;
        end else begin
          wr_data  = hold_r;
          hold_nxt = rd_val;
        end
        k_nxt     = k_r + ONE_C;
        state_nxt = (k_nxt == count_r) ? bdsd_pkg::ST_SORT_TAIL : bdsd_pkg::ST_SORT_RD;
      end

      bdsd_pkg::ST_SORT_TAIL: begin
        idx_sel   = k_r - ONE_C;
        wr_data   = hold_r;
        wr_en     = 1'b1;
        state_nxt = swapped_r ? bdsd_pkg::ST_SORT_LD : bdsd_pkg::ST_DONE;
      end

      bdsd_pkg::ST_DD_RDK: begin
        idx_sel   = k_r;
        rd_en     = 1'b1;
        state_nxt = bdsd_pkg::ST_DD_LDK;
      end

      bdsd_pkg::ST_DD_LDK: begin
        hold_nxt  = rd_val;
        j_nxt     = '0;
        state_nxt = (kept_r == '0) ? bdsd_pkg::ST_DD_WR : bdsd_pkg::ST_DD_RDJ;
      end

      bdsd_pkg::ST_DD_RDJ: begin
        idx_sel   = j_r;
        rd_en     = 1'b1;
        state_nxt = bdsd_pkg::ST_DD_CMP;
      end

      bdsd_pkg::ST_DD_CMP: begin
        if (cmp.eq) begin
          // drop the repeat and advance to the next entry
          k_nxt = k_r + ONE_C;
          if (k_nxt == count_r) begin
            count_nxt = kept_r;
            state_nxt = bdsd_pkg::ST_DONE;
          end else begin
            state_nxt = bdsd_pkg::ST_DD_RDK;
          end
        end else begin
          j_nxt     = j_r + ONE_C;
          state_nxt = (j_nxt == kept_r) ? bdsd_pkg::ST_DD_WR : bdsd_pkg::ST_DD_RDJ;
        end
      end

      bdsd_pkg::ST_DD_WR: begin
        idx_sel  = kept_r;
        wr_data  = hold_r;
        wr_en    = 1'b1;
        kept_nxt = kept_r + ONE_C;
        k_nxt    = k_r + ONE_C;
        if (k_nxt == count_r) begin
          count_nxt = kept_nxt;
          state_nxt = bdsd_pkg::ST_DONE;
        end else begin
          state_nxt = bdsd_pkg::ST_DD_RDK;
        end
      end

      bdsd_pkg::ST_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = bdsd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bdsd_pkg::ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.status  = out_status_r;
  assign out_chan.data    = out_data_r;
  assign out_chan.entries = out_entries_r;
  assign out_chan.last    = out_last_r;

endmodule

`default_nettype wire
